@@ rtl/core/spmq_pkg.sv @@
// Shared constants, types and helpers for the strict priority multi-queue core.
// No dependencies; imported by every module of the core.
package spmq_pkg;

  localparam int NUM_QUEUES   = 8;
  localparam int NUM_CLASSES  = 4;
  localparam int FIFO_DEPTH   = 8;
  localparam int HANDLE_WIDTH = 16;

  // Fixed port widths
  localparam int QSEL_W = 3;
  localparam int CLS_IN_W = 2;
  localparam int ITEM_W = 16;
  localparam int AQ_W = 4;

  localparam int Q_IDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W = Q_IDX_W + CLS_W + PTR_W;
  localparam int STORE_DEPTH = NUM_QUEUES * NUM_CLASSES * FIFO_DEPTH;

  localparam logic [AQ_W-1:0] ACTIVE_QUEUES_RESET = AQ_W'(8);

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  typedef logic [NUM_CLASSES-1:0][CNT_W-1:0] cnt_row_t;
  typedef logic [NUM_CLASSES-1:0][PTR_W-1:0] ptr_row_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

@@ rtl/core/spmq_ctrl.sv @@
// Sequencing state machine of the strict priority multi-queue core.
// Depends on spmq_pkg; drives the datapath commands and the handshake outputs.
module spmq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output spmq_pkg::dp_cmd_t  dp_cmd
);
  import spmq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;

  assign dp_cmd.capture = start && !busy;
  assign dp_cmd.execute = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_RESP;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        S_RESP: begin
          // result shows this cycle; a new transfer may already start
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/spmq_dp.sv @@
// Datapath of the strict priority multi-queue core: command registers, per-queue
// pointer and count rows, handle store and result registers. Depends on spmq_pkg.
module spmq_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  spmq_pkg::dp_cmd_t                      dp_cmd,
  input  logic                                   command,
  input  logic [spmq_pkg::QSEL_W-1:0]            queue_select,
  input  logic [spmq_pkg::CLS_IN_W-1:0]          priority_class,
  input  logic [spmq_pkg::ITEM_W-1:0]            item_handle,
  input  logic                                   cfg_write,
  input  logic [spmq_pkg::AQ_W-1:0]              cfg_data,
  output logic                                   item_valid,
  output logic [spmq_pkg::ITEM_W-1:0]            item_out,
  output logic [1:0]                             status
);
  import spmq_pkg::*;

  // captured command
  cmd_t                    cmd_r;
  logic [QSEL_W-1:0]       q_r;
  logic [CLS_IN_W-1:0]     cls_r;
  logic [HANDLE_WIDTH-1:0] handle_r;

  logic [AQ_W-1:0] active_queues;

  cnt_row_t fill_count   [NUM_QUEUES];
  ptr_row_t head_pointer [NUM_QUEUES];
  ptr_row_t tail_pointer [NUM_QUEUES];

  logic [HANDLE_WIDTH-1:0] item_store [STORE_DEPTH];
  logic [HANDLE_WIDTH-1:0] rd_data;

  logic    res_valid;
  status_t res_status;

  logic [Q_IDX_W-1:0] qi;
  logic [CLS_W-1:0]   enq_cls;
  logic               in_range;
  logic               cls_ok;
  cnt_row_t           cnt_row;
  ptr_row_t           hd_row;
  ptr_row_t           tl_row;
  logic               enq_full;
  logic               deq_found;
  logic [CLS_W-1:0]   deq_cls;
  logic               enq_ok;
  logic               deq_ok;
  status_t            status_next;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r    <= cmd_t'(command);
      q_r      <= queue_select;
      cls_r    <= priority_class;
      handle_r <= HANDLE_WIDTH'(item_handle);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_queues <= ACTIVE_QUEUES_RESET;
    end else if (cfg_write) begin
      active_queues <= cfg_data;
    end
  end

  assign qi      = Q_IDX_W'(q_r);
  assign enq_cls = CLS_W'(cls_r);

  assign in_range = (AQ_W'(q_r) < active_queues) && (32'(q_r) < NUM_QUEUES);
  assign cls_ok   = (32'(cls_r) < NUM_CLASSES);

  assign cnt_row = fill_count[qi];
  assign hd_row  = head_pointer[qi];
  assign tl_row  = tail_pointer[qi];

  assign enq_full = (cnt_row[enq_cls] >= CNT_W'(FIFO_DEPTH));

  // pick the highest-priority non-empty class
  always_comb begin
    deq_found = 1'b0;
    deq_cls   = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (cnt_row[c] != '0) begin
        deq_found = 1'b1;
        deq_cls   = CLS_W'(c);
      end
    end
  end

  always_comb begin
    enq_ok      = 1'b0;
    deq_ok      = 1'b0;
    status_next = ST_OK;
    if (!in_range) begin
      status_next = ST_RANGE;
    end else if (cmd_r == CMD_ENQ) begin
      if (!cls_ok || enq_full) begin
        status_next = ST_FULL;
      end else begin
        enq_ok = 1'b1;
      end
    end else begin
      if (deq_found) begin
        deq_ok = 1'b1;
      end else begin
        status_next = ST_EMPTY;
      end
    end
  end

  assign wr_addr = {qi, enq_cls, tl_row[enq_cls]};
  assign rd_addr = {qi, deq_cls, hd_row[deq_cls]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        fill_count[q]   <= '0;
        head_pointer[q] <= '0;
        tail_pointer[q] <= '0;
      end
    end else if (dp_cmd.execute) begin
      if (enq_ok) begin
        tail_pointer[qi][enq_cls] <= next_slot(tl_row[enq_cls]);
        fill_count[qi][enq_cls]   <= cnt_row[enq_cls] + 1'b1;
      end
      if (deq_ok) begin
        head_pointer[qi][deq_cls] <= next_slot(hd_row[deq_cls]);
        fill_count[qi][deq_cls]   <= cnt_row[deq_cls] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.execute && enq_ok) begin
      item_store[wr_addr] <= handle_r;
    end
    if (dp_cmd.execute && deq_ok) begin
      rd_data <= item_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      res_status <= ST_OK;
    end else if (dp_cmd.execute) begin
      res_valid  <= deq_ok;
      res_status <= status_next;
    end
  end

  assign item_valid = res_valid;
  assign item_out   = res_valid ? ITEM_W'(rd_data) : '0;
  assign status     = res_status;

endmodule

@@ rtl/core/strict_priority_multi_queue_core.sv @@
// Top level of the strict priority multi-queue core.
// Depends on spmq_pkg, spmq_ctrl and spmq_dp.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  command  | start / busy       | command, queue_select, priority_class, item_handle
//  result   | done (one cycle)   | item_valid, item_out, status
//  config   | cfg_write          | cfg_data (active_queues)
//
// A command is captured, then an execute step reads and updates the queue's pointer
// and count row and does the registered read of the handle store. The next command is
// taken in the cycle that shows the previous result. Reset clears pointers, counts and
// active_queues (to 8); the handle store is not cleared. The receiver cannot stall:
// every result is shown for exactly one cycle with done high.
module strict_priority_multi_queue_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [spmq_pkg::QSEL_W-1:0]       queue_select,
  input  logic [spmq_pkg::CLS_IN_W-1:0]     priority_class,
  input  logic [spmq_pkg::ITEM_W-1:0]       item_handle,
  output logic                              done,
  output logic                              item_valid,
  output logic [spmq_pkg::ITEM_W-1:0]       item_out,
  output logic [1:0]                        status,
  input  logic                              cfg_write,
  input  logic [spmq_pkg::AQ_W-1:0]         cfg_data
);
  import spmq_pkg::*;

  dp_cmd_t dp_cmd;

  spmq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .dp_cmd (dp_cmd)
  );

  spmq_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .dp_cmd         (dp_cmd),
    .command        (command),
    .queue_select   (queue_select),
    .priority_class (priority_class),
    .item_handle    (item_handle),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_out       (item_out),
    .status         (status)
  );

endmodule

@@ rtl/core/spmq_checker.sv @@
// Port-level checks for the strict priority multi-queue core, bound to the top.
// Depends on spmq_pkg and strict_priority_multi_queue_core.
module spmq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic                              item_valid,
  input logic [spmq_pkg::ITEM_W-1:0]       item_out,
  input logic [1:0]                        status
);
  import spmq_pkg::*;

  // an accepted transfer makes the core busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // busy lasts one cycle and is followed by the result
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("result did not follow busy");

  // results never come back to back
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (done && item_valid) |-> (status == ST_OK))
    else $error("returned item with a non-ok status");

  a_no_item_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !item_valid) |-> (item_out == '0 && status != ST_OK) || (done && !item_valid
      && item_out == '0 && status == ST_OK))
    else $error("item_out not zero without a returned item");

endmodule

bind strict_priority_multi_queue_core spmq_checker u_spmq_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for strict_priority_multi_queue_core: directed table, then random traffic.
// Depends on spmq_pkg for widths, command and status codes; holds its own model of the queues.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spmq_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_AQ  [NUM_PHASES] = '{8, 3, 1, 0, 15, 5, 8};
  localparam int PHASE_LEN [NUM_PHASES] = '{300, 120, 80, 30, 120, 100, 100};

  typedef struct packed {
    logic              valid;
    logic [ITEM_W-1:0] item;
    status_t           status;
  } qresult_t;

  typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    cmd_t                cmd;
    logic [QSEL_W-1:0]   q;
    logic [CLS_IN_W-1:0] cls;
    logic [ITEM_W-1:0]   handle;
    qresult_t            want;
    logic [AQ_W-1:0]     aq;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                command;
  logic [QSEL_W-1:0]   queue_select;
  logic [CLS_IN_W-1:0] priority_class;
  logic [ITEM_W-1:0]   item_handle;
  logic                done;
  logic                item_valid;
  logic [ITEM_W-1:0]   item_out;
  logic [1:0]          status;
  logic                cfg_write;
  logic [AQ_W-1:0]     cfg_data;

  // Model of the queue contents
  logic [ITEM_W-1:0] held_handle [NUM_QUEUES][NUM_CLASSES][FIFO_DEPTH];
  int unsigned       rd_slot     [NUM_QUEUES][NUM_CLASSES];
  int unsigned       wr_slot     [NUM_QUEUES][NUM_CLASSES];
  int unsigned       lane_fill   [NUM_QUEUES][NUM_CLASSES];
  int unsigned       active_model;

  qresult_t awaited_results [$];
  bit       table_row_on;
  qresult_t table_want;
  bit       gaps_on;

  int fail_count;
  int cycle_count;
  int cmds_seen, deq_hits, empty_hits, range_hits, full_hits, cfg_writes;

  strict_priority_multi_queue_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .queue_select   (queue_select),
    .priority_class (priority_class),
    .item_handle    (item_handle),
    .done           (done),
    .item_valid     (item_valid),
    .item_out       (item_out),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("strict_priority_multi_queue_core: mismatch");
    $finish;
  end

  function automatic qresult_t serve_command(input cmd_t cmd, input logic [QSEL_W-1:0] q,
                                             input logic [CLS_IN_W-1:0] cls,
                                             input logic [ITEM_W-1:0] h);
    qresult_t    r;
    int unsigned lim;
    r = '0;
    r.status = ST_OK;
    lim = (active_model > NUM_QUEUES) ? NUM_QUEUES : active_model;
    if (q >= lim) begin
      r.status = ST_RANGE;
    end else if (cmd == CMD_ENQ) begin
      if (lane_fill[q][cls] >= FIFO_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        held_handle[q][cls][wr_slot[q][cls]] = h;
        wr_slot[q][cls] = (wr_slot[q][cls] == FIFO_DEPTH - 1) ? 0 : wr_slot[q][cls] + 1;
        lane_fill[q][cls]++;
      end
    end else begin
      r.status = ST_EMPTY;
      // take the head of the first non-empty class, highest priority first
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (!r.valid && lane_fill[q][c] != 0) begin
          r.item = held_handle[q][c][rd_slot[q][c]];
          rd_slot[q][c] = (rd_slot[q][c] == FIFO_DEPTH - 1) ? 0 : rd_slot[q][c] + 1;
          lane_fill[q][c]--;
          r.valid = 1'b1;
          r.status = ST_OK;
        end
      end
    end
    return r;
  endfunction

  // Both sides sample pre-edge values at the rising edge
  always @(posedge clk) begin
    qresult_t want;
    qresult_t model_out;
    if (!rst) begin
      if (cfg_write) begin
        active_model = 32'(cfg_data);
        cfg_writes++;
      end
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited: item_valid %0b item_out %h status %0d",
                 item_valid, item_out, status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (item_valid !== want.valid) begin
            $error("item_valid: expected %0b, got %0b", want.valid, item_valid);
            fail_count++;
          end
          if (item_out !== want.item) begin
            $error("item_out: expected %h, got %h", want.item, item_out);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          case (status)
            ST_OK:    if (item_valid) deq_hits++;
            ST_EMPTY: empty_hits++;
            ST_RANGE: range_hits++;
            default:  full_hits++;
          endcase
        end
      end
      if (start && !busy) begin
        model_out = serve_command(cmd_t'(command), queue_select, priority_class, item_handle);
        awaited_results = {awaited_results, (table_row_on ? table_want : model_out)};
        cmds_seen++;
      end
    end
  end

  function automatic stim_row_t enq_row(input int q, input int cls, input int h,
                                        input status_t st);
    stim_row_t r;
    r.kind = ROW_CMD;
    r.cmd = CMD_ENQ;
    r.q = QSEL_W'(q);
    r.cls = CLS_IN_W'(cls);
    r.handle = ITEM_W'(h);
    r.want = '0;
    r.want.status = st;
    r.aq = '0;
    return r;
  endfunction

  function automatic stim_row_t deq_row(input int q, input bit valid, input int item,
                                        input status_t st);
    stim_row_t r;
    r.kind = ROW_CMD;
    r.cmd = CMD_DEQ;
    r.q = QSEL_W'(q);
    r.cls = 2'd3;
    r.handle = 16'hFFFF;
    r.want.valid = valid;
    r.want.item = ITEM_W'(item);
    r.want.status = st;
    r.aq = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input int aq);
    stim_row_t r;
    r = deq_row(0, 1'b0, 0, ST_OK);
    r.kind = ROW_CFG;
    r.aq = AQ_W'(aq);
    return r;
  endfunction

  task automatic issue(input cmd_t c, input logic [QSEL_W-1:0] q,
                       input logic [CLS_IN_W-1:0] k, input logic [ITEM_W-1:0] h,
                       input bit from_table, input qresult_t want);
    if (gaps_on) begin
      while ($urandom_range(99) < 14) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    command        <= c;
    queue_select   <= q;
    priority_class <= k;
    item_handle    <= h;
    table_row_on   <= from_table;
    table_want     <= want;
    start          <= 1'b1;
    // hold until the transfer is taken; start stays high for a following item
    do @(posedge clk); while (busy);
  endtask

  task automatic write_active(input logic [AQ_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    stim_row_t         rows [$];
    int                lim, hot_q, hot_cls, enq_pct, n, w;
    cmd_t              c;
    logic [QSEL_W-1:0] q;
    logic [CLS_IN_W-1:0] k;

    rst = 1'b1;
    start = 1'b0;
    command = 1'b0;
    queue_select = '0;
    priority_class = '0;
    item_handle = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    table_row_on = 1'b0;
    table_want = '0;
    gaps_on = 1'b1;
    active_model = 8;
    foreach (lane_fill[i, j]) begin
      rd_slot[i][j] = 0;
      wr_slot[i][j] = 0;
      lane_fill[i][j] = 0;
    end

    // Directed: empty queue, priority order, a full class, range limits, register extremes
    rows = {rows, deq_row(0, 1'b0, 0, ST_EMPTY)};
    rows = {rows, enq_row(0, 3, 16'hFFFF, ST_OK)};
    rows = {rows, enq_row(0, 0, 16'h0000, ST_OK)};
    rows = {rows, enq_row(0, 1, 16'hA5A5, ST_OK)};
    rows = {rows, deq_row(0, 1'b1, 16'h0000, ST_OK)};
    rows = {rows, deq_row(0, 1'b1, 16'hA5A5, ST_OK)};
    rows = {rows, deq_row(0, 1'b1, 16'hFFFF, ST_OK)};
    rows = {rows, deq_row(0, 1'b0, 0, ST_EMPTY)};
    for (int s = 0; s < FIFO_DEPTH; s++) rows = {rows, enq_row(7, 2, 16'h0700 + s, ST_OK)};
    rows = {rows, enq_row(7, 2, 16'h5A5A, ST_FULL)};
    rows = {rows, deq_row(7, 1'b1, 16'h0700, ST_OK)};
    rows = {rows, cfg_row(1)};
    rows = {rows, enq_row(1, 0, 16'h1111, ST_RANGE)};
    rows = {rows, deq_row(1, 1'b0, 0, ST_RANGE)};
    rows = {rows, enq_row(0, 2, 16'h2222, ST_OK)};
    rows = {rows, cfg_row(0)};
    rows = {rows, deq_row(0, 1'b0, 0, ST_RANGE)};
    rows = {rows, cfg_row(15)};
    rows = {rows, enq_row(7, 0, 16'h1234, ST_OK)};
    rows = {rows, deq_row(7, 1'b1, 16'h1234, ST_OK)};
    rows = {rows, deq_row(7, 1'b1, 16'h0701, ST_OK)};
    rows = {rows, cfg_row(8)};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG)
        write_active(rows[i].aq);
      else
        issue(rows[i].cmd, rows[i].q, rows[i].cls, rows[i].handle, 1'b1, rows[i].want);
    end

    // Random: each chunk either mostly fills or mostly drains a hot queue and class, picked at random
    n = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_active(AQ_W'(PHASE_AQ[p]));
      lim = (PHASE_AQ[p] > NUM_QUEUES) ? NUM_QUEUES : PHASE_AQ[p];
      for (int i = 0; i < PHASE_LEN[p]; i++) begin
        if (i % 48 == 0) begin
          enq_pct = $urandom_range(1) ? 80 : 25;
          hot_q   = (lim > 0) ? $urandom_range(lim - 1) : 0;
          hot_cls = $urandom_range(3);
        end
        gaps_on = !(n >= 250 && n < 450);
        c = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        if (lim == 0 || $urandom_range(99) < 10)
          q = QSEL_W'($urandom_range(NUM_QUEUES - 1));
        else if ($urandom_range(99) < 65)
          q = QSEL_W'(hot_q);
        else
          q = QSEL_W'($urandom_range(lim - 1));
        k = ($urandom_range(99) < 60) ? CLS_IN_W'(hot_cls) : CLS_IN_W'($urandom_range(3));
        issue(c, q, k, ITEM_W'($urandom_range(16'hFFFF)), 1'b0, '0);
        n++;
      end
    end

    start <= 1'b0;
    @(posedge clk);
    w = 0;
    while (awaited_results.size() != 0 && w < 200) begin
      @(posedge clk);
      w++;
    end
    repeat (4) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      fail_count++;
    end

    $display("%0d commands: %0d handles returned, %0d empty, %0d out of range, %0d dropped full",
             cmds_seen, deq_hits, empty_hits, range_hits, full_hits);
    $display("%0d active_queues writes, settings from 0 to 15", cfg_writes);
    if (fail_count == 0)
      $display("strict_priority_multi_queue_core: match");
    else
      $display("strict_priority_multi_queue_core: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/spmq_pkg.sv
rtl/core/spmq_ctrl.sv
rtl/core/spmq_dp.sv
rtl/core/strict_priority_multi_queue_core.sv
rtl/core/spmq_checker.sv
sim/tb_top.sv
